FILE: rtl/core/wbf_pkg.sv
package wbf_pkg;

  // Width of every internal index, length and scan result.
  localparam int IDX_W = 14;

  // Default depth of the byte store.
  localparam int STORE_DEPTH_DEF = 4096;

  // Below this length the previous-word-start query always answers zero.
  localparam int SHORT_LEN = 3;

  // Operation codes.
  localparam logic [3:0] OP_WRITE       = 4'd0;
  localparam logic [3:0] OP_PREV_START  = 4'd1;
  localparam logic [3:0] OP_NEXT_START  = 4'd2;
  localparam logic [3:0] OP_BEFORE_NEXT = 4'd3;
  localparam logic [3:0] OP_LEFT_SEL    = 4'd4;
  localparam logic [3:0] OP_RIGHT_SEL   = 4'd5;
  localparam logic [3:0] OP_SECTION     = 4'd6;

  // Character class codes; the spare code behaves like CLS_ANY, so every byte
  // is a word byte under both.
  localparam logic [1:0] CLS_PRINT = 2'd0;
  localparam logic [1:0] CLS_ALNUM = 2'd1;
  localparam logic [1:0] CLS_ANY   = 2'd2;
  localparam logic [1:0] CLS_SPARE = 2'd3;

  // Launch command for the scan unit.
  typedef struct packed {
    logic             go_left;   // scan toward index 0
    logic             target;    // word-byte value that ends the scan
    logic             need_arm;  // the opposite kind must be seen first
    logic             skip;      // right scans begin one past the origin
    logic [IDX_W-1:0] origin;
    logic [1:0]       cls;
  } scan_cmd_t;

  // Classifies one byte as a word byte under the given class.
  function automatic logic word_byte(input logic [7:0] b, input logic [1:0] cls);
    logic res;
    case (cls)
      CLS_PRINT: res = (b >= 8'h20) && (b <= 8'h7E);
      CLS_ALNUM: res = ((b >= 8'h30) && (b <= 8'h39)) ||
                       ((b >= 8'h41) && (b <= 8'h5A)) ||
                       ((b >= 8'h61) && (b <= 8'h7A));
      default:   res = 1'b1;
    endcase
    return res;
  endfunction

endpackage

FILE: rtl/core/wbf_ram.sv
module wbf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4096
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port and one registered read port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule

FILE: rtl/core/wbf_scan.sv
module wbf_scan (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      go_i,
  input  wbf_pkg::scan_cmd_t        cmd_i,
  input  logic [wbf_pkg::IDX_W-1:0] len_i,
  output logic                      rd_en_o,
  output logic [wbf_pkg::IDX_W-1:0] rd_idx_o,
  input  logic [7:0]                rd_data_i,
  output logic                      done_o,
  output logic [wbf_pkg::IDX_W-1:0] result_o
);

  import wbf_pkg::*;

  // Issue stage: the next index to read.
  logic             issuing_q, issuing_d;
  logic [IDX_W-1:0] ic_q, ic_d;
  // Check stage: the index whose byte arrives from the store this cycle.
  logic             cv_q, cv_d;
  logic             last_q, last_d;
  logic [IDX_W-1:0] ci_q, ci_d;
  // Scan setup held for the whole scan.
  logic             left_q, left_d;
  logic             target_q, target_d;
  logic             armed_q, armed_d;
  logic [1:0]       cls_q, cls_d;
  // Registered result.
  logic             done_q, done_d;
  logic [IDX_W-1:0] res_q, res_d;

  logic             w;
  logic             hit;
  logic [IDX_W-1:0] first_idx;
  logic             empty;

  assign w   = word_byte(rd_data_i, cls_q);
  assign hit = cv_q && armed_q && (w == target_q);

  // First index and the case of nothing to scan.
  always_comb begin
    if (cmd_i.go_left) begin
      first_idx = cmd_i.origin - IDX_W'(1);
      empty     = (cmd_i.origin == '0);
    end else begin
      first_idx = cmd_i.origin + IDX_W'(cmd_i.skip);
      empty     = (first_idx >= len_i);
    end
  end

  // Two-stage scan: one byte read and one byte checked in every cycle.
  always_comb begin
    issuing_d = issuing_q;
    ic_d      = ic_q;
    cv_d      = 1'b0;
    last_d    = last_q;
    ci_d      = ci_q;
    left_d    = left_q;
    target_d  = target_q;
    armed_d   = armed_q;
    cls_d     = cls_q;
    done_d    = 1'b0;
    res_d     = res_q;
    if (go_i) begin
      left_d   = cmd_i.go_left;
      target_d = cmd_i.target;
      armed_d  = !cmd_i.need_arm;
      cls_d    = cmd_i.cls;
      ic_d     = first_idx;
      if (empty) begin
        issuing_d = 1'b0;
        done_d    = 1'b1;
        res_d     = cmd_i.go_left ? '0 : len_i;
      end else begin
        issuing_d = 1'b1;
      end
    end else begin
      if (cv_q) begin
        if (hit) begin
          done_d    = 1'b1;
          res_d     = left_q ? ci_q + IDX_W'(1) : ci_q;
          issuing_d = 1'b0;
        end else begin
          armed_d = armed_q | (w != target_q);
          if (last_q) begin
            done_d = 1'b1;
            res_d  = left_q ? '0 : len_i;
          end
        end
      end
      if (issuing_q && !hit) begin
        cv_d      = 1'b1;
        ci_d      = ic_q;
        last_d    = left_q ? (ic_q == '0) : (ic_q == len_i - IDX_W'(1));
        ic_d      = left_q ? ic_q - IDX_W'(1) : ic_q + IDX_W'(1);
        issuing_d = !last_d;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      issuing_q <= 1'b0;
      cv_q      <= 1'b0;
      done_q    <= 1'b0;
    end else begin
      issuing_q <= issuing_d;
      cv_q      <= cv_d;
      done_q    <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ic_q     <= ic_d;
    last_q   <= last_d;
    ci_q     <= ci_d;
    left_q   <= left_d;
    target_q <= target_d;
    armed_q  <= armed_d;
    cls_q    <= cls_d;
    res_q    <= res_d;
  end

  assign rd_en_o  = issuing_q;
  assign rd_idx_o = ic_q;
  assign done_o   = done_q;
  assign result_o = res_q;

endmodule

FILE: rtl/core/word_boundary_finder.sv
// Word boundary finder. A word is accepted when start is high and busy is low,
// and each word gives exactly one result, shown for one cycle with done_o high;
// the receiver cannot stall it. A write word or a word that is answered at once
// (bad position, unknown op, short store) shows its result in the next cycle and
// the block is ready again in that same cycle. A query that scans reads the byte
// store at one byte per cycle through a single read port; the worst case is a
// full scan of the used length, and a section query scans both sides of the
// position. Write used_length only while the block is idle; bytes that a query
// may read must have been written first.
module word_boundary_finder #(
  parameter int STORE_DEPTH = wbf_pkg::STORE_DEPTH_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [12:0]        cfg_wdata_i,
  input  logic               start,
  output logic               busy,
  input  logic [3:0]         op_i,
  input  logic [11:0]        position_i,
  input  logic [7:0]         write_byte_i,
  input  logic [1:0]         char_class_i,
  output logic               done_o,
  output logic signed [13:0] result_index_o,
  output logic signed [12:0] section_end_o,
  output logic               word_found_o,
  output logic               bad_position_o
);

  import wbf_pkg::*;

  localparam int          AW      = $clog2(STORE_DEPTH);
  localparam logic [31:0] DEPTH_U = 32'(STORE_DEPTH);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_PROBE,
    ST_SCAN_A,
    ST_SCAN_B
  } state_e;

  state_e           state_q;
  logic [12:0]      used_length_q;
  logic [3:0]       op_q;
  logic [11:0]      pos_q;
  logic [1:0]       cls_q;
  logic [IDX_W-1:0] sec_start_q;
  logic             done_q;
  logic [13:0]      res_q;
  logic [12:0]      send_q;
  logic             found_q;
  logic             bad_q;

  logic             accept;
  logic [IDX_W-1:0] len_eff;
  logic             bad_now;
  logic             short_now;
  logic             is_query;
  logic             probe_rd;
  logic             ram_we;
  logic             probe_w;

  logic             scan_go;
  scan_cmd_t        scan_cmd;
  logic             scan_rd_en;
  logic [IDX_W-1:0] scan_rd_idx;
  logic             scan_done;
  logic [IDX_W-1:0] scan_res;
  logic [7:0]       rd_data;

  assign busy   = (state_q != ST_IDLE);
  assign accept = start && !busy;

  // Effective length is the register limited to the store depth.
  assign len_eff   = ({19'd0, used_length_q} > DEPTH_U) ? IDX_W'(DEPTH_U)
                                                        : {1'b0, used_length_q};
  assign bad_now   = ({2'b00, position_i} >= len_eff);
  assign short_now = (position_i == '0) || (len_eff < IDX_W'(SHORT_LEN));

  always_comb begin
    case (op_i)
      OP_PREV_START, OP_NEXT_START, OP_BEFORE_NEXT,
      OP_LEFT_SEL, OP_RIGHT_SEL, OP_SECTION: is_query = 1'b1;
      default:                               is_query = 1'b0;
    endcase
  end

  // Store write and the probe read of the byte at the position.
  assign ram_we   = accept && (op_i == OP_WRITE) && ({20'd0, position_i} < DEPTH_U);
  assign probe_rd = accept && !bad_now &&
                    ((op_i == OP_LEFT_SEL) || (op_i == OP_RIGHT_SEL) ||
                     (op_i == OP_SECTION));
  assign probe_w  = word_byte(rd_data, cls_q);

  wbf_ram #(
    .WIDTH (8),
    .DEPTH (STORE_DEPTH)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (AW'(position_i)),
    .wdata_i (write_byte_i),
    .re_i    (probe_rd || scan_rd_en),
    .raddr_i (probe_rd ? AW'(position_i) : AW'(scan_rd_idx)),
    .rdata_o (rd_data)
  );

  // Scan launches for each query kind.
  always_comb begin
    scan_go         = 1'b0;
    scan_cmd        = '0;
    scan_cmd.origin = (state_q == ST_IDLE) ? {2'b00, position_i} : {2'b00, pos_q};
    scan_cmd.cls    = (state_q == ST_IDLE) ? char_class_i : cls_q;
    unique case (state_q)
      ST_IDLE: begin
        if (accept && !bad_now) begin
          if ((op_i == OP_PREV_START) && !short_now) begin
            scan_go           = 1'b1;
            scan_cmd.go_left  = 1'b1;
            scan_cmd.target   = 1'b0;
            scan_cmd.need_arm = 1'b1;
          end else if ((op_i == OP_NEXT_START) || (op_i == OP_BEFORE_NEXT)) begin
            scan_go           = 1'b1;
            scan_cmd.target   = 1'b1;
            scan_cmd.need_arm = 1'b1;
          end
        end
      end
      ST_PROBE: begin
        if (op_q == OP_LEFT_SEL) begin
          scan_go          = 1'b1;
          scan_cmd.go_left = probe_w;
          scan_cmd.target  = !probe_w;
          scan_cmd.skip    = 1'b1;
        end else if (op_q == OP_RIGHT_SEL) begin
          scan_go          = 1'b1;
          scan_cmd.go_left = !probe_w;
          scan_cmd.target  = !probe_w;
          scan_cmd.skip    = 1'b1;
        end else if (probe_w) begin
          scan_go          = 1'b1;
          scan_cmd.go_left = 1'b1;
        end
      end
      ST_SCAN_A: begin
        if ((op_q == OP_SECTION) && scan_done) begin
          scan_go       = 1'b1;
          scan_cmd.skip = 1'b1;
        end
      end
      ST_SCAN_B: begin
      end
      default: begin
      end
    endcase
  end

  wbf_scan u_scan (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .go_i      (scan_go),
    .cmd_i     (scan_cmd),
    .len_i     (len_eff),
    .rd_en_o   (scan_rd_en),
    .rd_idx_o  (scan_rd_idx),
    .rd_data_i (rd_data),
    .done_o    (scan_done),
    .result_o  (scan_res)
  );

  // Configuration register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      used_length_q <= '0;
    end else if (cfg_we_i) begin
      used_length_q <= cfg_wdata_i;
    end
  end

  // Sequencer with the registered result.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      op_q        <= '0;
      pos_q       <= '0;
      cls_q       <= '0;
      sec_start_q <= '0;
      done_q      <= 1'b0;
      res_q       <= '0;
      send_q      <= '0;
      found_q     <= 1'b0;
      bad_q       <= 1'b0;
    end else begin
      done_q <= 1'b0;
      unique case (state_q)
        ST_IDLE: begin
          if (accept) begin
            op_q  <= op_i;
            pos_q <= position_i;
            cls_q <= char_class_i;
            if (!is_query || bad_now ||
                ((op_i == OP_PREV_START) && short_now)) begin
              // Answered at once.
              done_q  <= 1'b1;
              res_q   <= '0;
              send_q  <= '0;
              found_q <= 1'b0;
              bad_q   <= is_query && bad_now;
            end else if ((op_i == OP_PREV_START) || (op_i == OP_NEXT_START) ||
                         (op_i == OP_BEFORE_NEXT)) begin
              state_q <= ST_SCAN_A;
            end else begin
              state_q <= ST_PROBE;
            end
          end
        end
        ST_PROBE: begin
          if ((op_q == OP_SECTION) && !probe_w) begin
            // No word at the position.
            done_q  <= 1'b1;
            res_q   <= '1;
            send_q  <= '1;
            found_q <= 1'b0;
            bad_q   <= 1'b0;
            state_q <= ST_IDLE;
          end else begin
            state_q <= ST_SCAN_A;
          end
        end
        ST_SCAN_A: begin
          if (scan_done) begin
            if (op_q == OP_SECTION) begin
              sec_start_q <= scan_res;
              state_q     <= ST_SCAN_B;
            end else begin
              done_q  <= 1'b1;
              res_q   <= (op_q == OP_BEFORE_NEXT) ? scan_res - IDX_W'(1) : scan_res;
              send_q  <= '0;
              found_q <= 1'b0;
              bad_q   <= 1'b0;
              state_q <= ST_IDLE;
            end
          end
        end
        ST_SCAN_B: begin
          if (scan_done) begin
            done_q  <= 1'b1;
            res_q   <= sec_start_q;
            send_q  <= 13'(scan_res - IDX_W'(1));
            found_q <= 1'b1;
            bad_q   <= 1'b0;
            state_q <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign done_o         = done_q;
  assign result_index_o = $signed(res_q);
  assign section_end_o  = $signed(send_q);
  assign word_found_o   = found_q;
  assign bad_position_o = bad_q;

endmodule

FILE: bench/word_boundary_finder_test.sv
`timescale 1ns / 100ps

module word_boundary_finder_test;
  import wbf_pkg::*;

  localparam int DEPTH = STORE_DEPTH_DEF;
  localparam int CYCLE_LIMIT = 4_000_000;
  localparam int ITEMS_PER_PHASE = 10;
  localparam logic [3:0] OP_MAX = 4'hF;

  // Expected answer of one word, at the widths of the result ports.
  typedef struct packed {
    logic signed [13:0] idx;
    logic signed [12:0] sec_end;
    logic               in_word;
    logic               bad_pos;
  } answer_t;

  // One line of the directed stimulus: a length setting or a word.
  typedef struct packed {
    logic        is_cfg;
    logic [12:0] cfg_value;
    logic [3:0]  op_code;
    logic [11:0] pos;
    logic [7:0]  data;
    logic [1:0]  cls;
    logic        typed;
    answer_t     answer;
  } stim_row_t;

  logic               clk;
  logic               rst_n;
  logic               cfg_we;
  logic [12:0]        cfg_wdata;
  logic               start;
  logic               busy;
  logic [3:0]         op;
  logic [11:0]        position;
  logic [7:0]         write_byte;
  logic [1:0]         char_class;
  logic               done;
  logic signed [13:0] result_index;
  logic signed [12:0] section_end;
  logic               word_found;
  logic               bad_position;

  // Mirror of the text store and of the length register.
  logic [7:0] text_mirror [DEPTH];
  bit         written [DEPTH];
  int         length_reg;
  answer_t    pending_answers [$];
  answer_t    oldest;
  int         errors;
  int         calm_items;
  int         cycle_count;

  word_boundary_finder uut (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .cfg_we_i      (cfg_we),
    .cfg_wdata_i   (cfg_wdata),
    .start         (start),
    .busy          (busy),
    .op_i          (op),
    .position_i    (position),
    .write_byte_i  (write_byte),
    .char_class_i  (char_class),
    .done_o        (done),
    .result_index_o(result_index),
    .section_end_o (section_end),
    .word_found_o  (word_found),
    .bad_position_o(bad_position)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // The scan never looks past the store, however large the register is.
  function automatic int eff_length();
    return (length_reg > DEPTH) ? DEPTH : length_reg;
  endfunction

  function automatic bit is_word_char(int i, logic [1:0] cls);
    logic [7:0] b;
    b = text_mirror[i];
    case (cls)
      CLS_PRINT: return (b >= 8'h20) && (b <= 8'h7E);
      CLS_ALNUM: return ((b >= "0") && (b <= "9")) || ((b >= "A") && (b <= "Z")) ||
                        ((b >= "a") && (b <= "z"));
      default:   return 1'b1;
    endcase
  endfunction

  // Nearest index at or left of from whose kind is want, or -1.
  function automatic int scan_left(int from, logic [1:0] cls, bit want);
    for (int i = from; i >= 0; i--)
      if (is_word_char(i, cls) == want) return i;
    return -1;
  endfunction

  // Nearest index at or right of from whose kind is want, or len.
  function automatic int scan_right(int from, int len, logic [1:0] cls, bit want);
    for (int i = from; i < len; i++)
      if (is_word_char(i, cls) == want) return i;
    return len;
  endfunction

  function automatic answer_t predict_answer(logic [3:0] op_code, int pos, logic [1:0] cls);
    answer_t a;
    int      len;
    int      r;
    int      e;
    int      j;
    a = '0;
    len = eff_length();
    r = 0;
    e = 0;
    if (op_code == OP_WRITE || op_code > OP_SECTION) return a;
    if (pos >= len) begin
      a.bad_pos = 1'b1;
      return a;
    end
    case (op_code)
      OP_PREV_START: begin
        // Skip the gap to the left, then walk back over the word found there.
        if (pos > 0 && len >= SHORT_LEN) begin
          j = scan_left(pos - 1, cls, 1'b1);
          r = (j < 0) ? 0 : scan_left(j - 1, cls, 1'b0) + 1;
        end
      end
      OP_NEXT_START, OP_BEFORE_NEXT: begin
        // A word start only counts once a gap has been crossed.
        j = scan_right(pos, len, cls, 1'b0);
        r = (j >= len) ? len : scan_right(j + 1, len, cls, 1'b1);
        if (op_code == OP_BEFORE_NEXT) r = r - 1;
      end
      OP_LEFT_SEL: begin
        r = is_word_char(pos, cls) ? scan_left(pos - 1, cls, 1'b0) + 1
                                   : scan_right(pos + 1, len, cls, 1'b1);
      end
      OP_RIGHT_SEL: begin
        r = is_word_char(pos, cls) ? scan_right(pos + 1, len, cls, 1'b0)
                                   : scan_left(pos - 1, cls, 1'b1) + 1;
      end
      default: begin
        if (is_word_char(pos, cls)) begin
          a.in_word = 1'b1;
          r = scan_left(pos - 1, cls, 1'b0) + 1;
          e = scan_right(pos + 1, len, cls, 1'b0) - 1;
        end else begin
          r = -1;
          e = -1;
        end
      end
    endcase
    a.idx = r[13:0];
    a.sec_end = e[12:0];
    return a;
  endfunction

  // Text-like bytes: letters and digits, split by spaces, punctuation,
  // control codes and high bytes.
  function automatic logic [7:0] text_byte();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 25) return 8'(8'h61 + $urandom_range(0, 25));
    if (pick < 35) return 8'(8'h41 + $urandom_range(0, 25));
    if (pick < 45) return 8'(8'h30 + $urandom_range(0, 9));
    if (pick < 60) return 8'h20;
    if (pick < 70) return 8'(8'h21 + $urandom_range(0, 14));
    if (pick < 78) return $urandom_range(0, 1) ? 8'h7F : 8'($urandom_range(0, 31));
    if (pick < 88) return 8'($urandom_range(128, 255));
    return 8'($urandom_range(0, 255));
  endfunction

  function automatic stim_row_t cfg_row(logic [12:0] v);
    stim_row_t r;
    r = '0;
    r.is_cfg = 1'b1;
    r.cfg_value = v;
    return r;
  endfunction

  function automatic stim_row_t item_row(logic [3:0] op_code, logic [11:0] pos,
                                         logic [7:0] data, logic [1:0] cls);
    stim_row_t r;
    r = '0;
    r.op_code = op_code;
    r.pos = pos;
    r.data = data;
    r.cls = cls;
    return r;
  endfunction

  function automatic stim_row_t fixed_row(logic [3:0] op_code, logic [11:0] pos,
                                          logic [7:0] data, logic [1:0] cls,
                                          int idx, int sec_end, int in_word, int bad_pos);
    stim_row_t r;
    r = item_row(op_code, pos, data, cls);
    r.typed = 1'b1;
    r.answer.idx = idx[13:0];
    r.answer.sec_end = sec_end[12:0];
    r.answer.in_word = in_word[0];
    r.answer.bad_pos = bad_pos[0];
    return r;
  endfunction

  // Offers one word after a random gap and records its answer once accepted.
  // Start stays high on return so that a following word can go back to back.
  task automatic send_word(logic [3:0] op_code, logic [11:0] pos, logic [7:0] data,
                           logic [1:0] cls, bit typed, answer_t typed_answer);
    int      gap;
    answer_t a;
    if (calm_items > 0) begin
      calm_items--;
      gap = 0;
    end else begin
      if ($urandom_range(0, 9) == 0) calm_items = $urandom_range(4, 12);
      gap = $urandom_range(0, 3);
    end
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    op <= op_code;
    position <= pos;
    write_byte <= data;
    char_class <= cls;
    @(posedge clk);
    while (busy) @(posedge clk);
    a = typed ? typed_answer : predict_answer(op_code, int'(pos), cls);
    if (op_code == OP_WRITE) begin
      text_mirror[pos] = data;
      written[pos] = 1'b1;
    end
    pending_answers.push_back(a);
  endtask

  task automatic wait_idle();
    start <= 1'b0;
    while (pending_answers.size() != 0) @(posedge clk);
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  // Fills every byte that the new length exposes and has never been written,
  // then writes the register while the block is idle. A length at or past the
  // store depth leaves the store as it is; only queries that read the top
  // entry follow such a length.
  task automatic set_length(int value);
    int      span;
    answer_t none;
    none = '0;
    span = (value < DEPTH) ? value : 0;
    for (int i = 0; i < span; i++)
      if (!written[i])
        send_word(OP_WRITE, 12'(i), text_byte(), 2'($urandom_range(0, 3)), 1'b0, none);
    wait_idle();
    cfg_we <= 1'b1;
    cfg_wdata <= 13'(value);
    @(posedge clk);
    cfg_we <= 1'b0;
    length_reg = value;
  endtask

  // Result checking: every strobe takes the oldest expectation.
  always @(posedge clk) begin
    if (rst_n && done) begin
      if (pending_answers.size() == 0) begin
        $error("result strobe with no word outstanding");
        errors++;
      end else begin
        oldest = pending_answers.pop_front();
        if (result_index !== oldest.idx) begin
          $error("result_index: expected %0d, got %0d", oldest.idx, result_index);
          errors++;
        end
        if (section_end !== oldest.sec_end) begin
          $error("section_end: expected %0d, got %0d", oldest.sec_end, section_end);
          errors++;
        end
        if (word_found !== oldest.in_word) begin
          $error("word_found: expected %0d, got %0d", oldest.in_word, word_found);
          errors++;
        end
        if (bad_position !== oldest.bad_pos) begin
          $error("bad_position: expected %0d, got %0d", oldest.bad_pos, bad_position);
          errors++;
        end
      end
    end
  end

  // Watchdog on the whole run.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("word_boundary_finder test failed");
      $finish;
    end
  end

  initial begin
    stim_row_t   plan [$];
    stim_row_t   row;
    int          lengths [9];
    int          len;
    int          kind;
    int          sel;
    int          top;
    logic [3:0]  op_code;
    logic [11:0] pos;
    logic [7:0]  data;
    answer_t     none;

    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    start = 1'b0;
    op = OP_WRITE;
    position = '0;
    write_byte = '0;
    char_class = CLS_PRINT;
    errors = 0;
    calm_items = 0;
    cycle_count = 0;
    length_reg = 0;
    none = '0;

    // Empty store after reset: every query is out of range, unknown codes
    // and writes answer all zero.
    plan.push_back(fixed_row(OP_PREV_START, 12'd0, 8'h00, CLS_PRINT, 0, 0, 0, 1));
    plan.push_back(fixed_row(OP_SECTION, 12'hFFF, 8'hFF, CLS_SPARE, 0, 0, 0, 1));
    plan.push_back(fixed_row(OP_MAX, 12'hFFF, 8'hFF, CLS_SPARE, 0, 0, 0, 0));
    plan.push_back(fixed_row(OP_SECTION + 4'd1, 12'd0, 8'h00, CLS_PRINT, 0, 0, 0, 0));
    // A short text with a word under every class, plus the last store entry.
    plan.push_back(fixed_row(OP_WRITE, 12'd0, "a", CLS_PRINT, 0, 0, 0, 0));
    plan.push_back(fixed_row(OP_WRITE, 12'd1, 8'h7E, CLS_PRINT, 0, 0, 0, 0));
    plan.push_back(fixed_row(OP_WRITE, 12'd2, 8'h20, CLS_PRINT, 0, 0, 0, 0));
    plan.push_back(fixed_row(OP_WRITE, 12'd3, 8'h00, CLS_PRINT, 0, 0, 0, 0));
    plan.push_back(fixed_row(OP_WRITE, 12'd4, "Z", CLS_PRINT, 0, 0, 0, 0));
    plan.push_back(fixed_row(OP_WRITE, 12'd5, "9", CLS_PRINT, 0, 0, 0, 0));
    plan.push_back(fixed_row(OP_WRITE, 12'd6, 8'h80, CLS_PRINT, 0, 0, 0, 0));
    plan.push_back(fixed_row(OP_WRITE, 12'd7, 8'hFF, CLS_PRINT, 0, 0, 0, 0));
    plan.push_back(fixed_row(OP_WRITE, 12'hFFF, 8'hFF, CLS_SPARE, 0, 0, 0, 0));
    plan.push_back(cfg_row(13'd8));
    plan.push_back(item_row(OP_PREV_START, 12'd7, 8'h00, CLS_ALNUM));
    plan.push_back(item_row(OP_NEXT_START, 12'd0, 8'h00, CLS_PRINT));
    plan.push_back(item_row(OP_BEFORE_NEXT, 12'd4, 8'h00, CLS_ALNUM));
    plan.push_back(item_row(OP_LEFT_SEL, 12'd3, 8'h00, CLS_PRINT));
    plan.push_back(item_row(OP_RIGHT_SEL, 12'd4, 8'h00, CLS_ALNUM));
    plan.push_back(item_row(OP_SECTION, 12'd5, 8'h00, CLS_ALNUM));
    plan.push_back(fixed_row(OP_SECTION, 12'd3, 8'h00, CLS_ALNUM, -1, -1, 0, 0));
    plan.push_back(item_row(OP_SECTION, 12'd7, 8'h00, CLS_ANY));
    plan.push_back(fixed_row(OP_PREV_START, 12'd0, 8'h00, CLS_ANY, 0, 0, 0, 0));
    plan.push_back(fixed_row(OP_RIGHT_SEL, 12'd8, 8'h00, CLS_PRINT, 0, 0, 0, 1));
    // Largest register value: the length is limited to the store depth, and
    // these queries only read the last store entry.
    plan.push_back(cfg_row(13'd8191));
    plan.push_back(fixed_row(OP_NEXT_START, 12'hFFF, 8'h00, CLS_ANY, 4096, 0, 0, 0));
    plan.push_back(fixed_row(OP_BEFORE_NEXT, 12'hFFF, 8'h00, CLS_ANY, 4095, 0, 0, 0));
    plan.push_back(fixed_row(OP_RIGHT_SEL, 12'hFFF, 8'h00, CLS_ANY, 4096, 0, 0, 0));
    // Too short a store for a previous word start.
    plan.push_back(cfg_row(13'd2));
    plan.push_back(fixed_row(OP_PREV_START, 12'd1, 8'h00, CLS_ALNUM, 0, 0, 0, 0));
    plan.push_back(item_row(OP_LEFT_SEL, 12'd1, 8'h00, CLS_SPARE));

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    foreach (plan[i]) begin
      row = plan[i];
      if (row.is_cfg) set_length(int'(row.cfg_value));
      else send_word(row.op_code, row.pos, row.data, row.cls, row.typed, row.answer);
    end

    // Random phases over a spread of lengths, the empty register among them.
    lengths = '{12, 3, 1, 40, 0, 50, 2, 25, 7};
    foreach (lengths[p]) begin
      set_length(lengths[p]);
      len = eff_length();
      repeat (ITEMS_PER_PHASE) begin
        kind = $urandom_range(0, 99);
        sel = $urandom_range(0, 9);
        if (kind < 30) op_code = OP_WRITE;
        else if (kind < 95) op_code = 4'($urandom_range(OP_PREV_START, OP_SECTION));
        else op_code = 4'($urandom_range(OP_SECTION + 1, OP_MAX));
        if (op_code == OP_WRITE) begin
          top = (len + 8 > DEPTH - 1) ? DEPTH - 1 : len + 8;
          pos = (sel < 7) ? 12'($urandom_range(0, top)) : 12'($urandom_range(0, DEPTH - 1));
          data = text_byte();
        end else begin
          if (len > 0 && sel < 7) pos = 12'($urandom_range(0, len - 1));
          else if (len > 0 && sel == 7) pos = $urandom_range(0, 1) ? 12'd0 : 12'(len - 1);
          else pos = 12'($urandom_range(0, DEPTH - 1));
          data = 8'($urandom_range(0, 255));
        end
        send_word(op_code, pos, data, 2'($urandom_range(0, 3)), 1'b0, none);
      end
    end

    wait_idle();
    repeat (20) @(posedge clk);
    if (errors == 0) begin
      $display("word_boundary_finder test passed");
    end else begin
      $display("word_boundary_finder test failed");
    end
    $finish;
  end

endmodule

FILE: word_boundary_finder.f
rtl/core/wbf_pkg.sv
rtl/core/wbf_ram.sv
rtl/core/wbf_scan.sv
rtl/core/word_boundary_finder.sv
bench/word_boundary_finder_test.sv
